// ----- hdl/rmsp_pkg.sv -----
// Shared types, constants and datapath step functions for the RMSProp update block.
// Used by every module in hdl/ except rmsp_ram; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none
package rmsp_pkg;

    localparam int ELEMENTS_DEF = 1024;

    localparam logic [15:0] DECAY_RST   = 16'd58982;
    localparam logic [23:0] LR_RST      = 24'd655;
    localparam logic [31:0] EPS_RST     = 32'd4295;

    localparam int NUM_W     = 56;             // lr (24) times |g| (32)
    localparam int SQRT_STG  = 16;             // two root bits per stage
    localparam int DIV_STG   = NUM_W / 2;      // two quotient bits per stage

    typedef enum logic [1:0] {
        REG_DECAY = 2'd0,
        REG_LR    = 2'd1,
        REG_EPS   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [9:0]         element_index;
        logic signed [31:0] param_value;
        logic signed [31:0] gradient;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_param;
        logic               saturated;
    } out_item_t;

    // Values that ride along with a request through the pipeline.
    typedef struct packed {
        logic [31:0]      param;
        logic             gneg;
        logic             sat;
        logic [NUM_W-1:0] num;
    } side_t;

    typedef struct packed {
        logic [35:0] rem;
        logic [31:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic [31:0] rem;
        logic        qbit;
    } div_st_t;

    // One digit-by-digit root iteration (floor square root).
    function automatic sqrt_st_t sqrt_iter(input sqrt_st_t cur, input logic [1:0] bits);
        sqrt_st_t    nxt;
        logic [35:0] r;
        logic [35:0] trial;
        r     = {cur.rem[33:0], bits};
        trial = {2'b00, cur.root, 2'b01};
        if (r >= trial)
        begin
            nxt.rem  = r - trial;
            nxt.root = {cur.root[30:0], 1'b1};
        end
        else
        begin
            nxt.rem  = r;
            nxt.root = {cur.root[30:0], 1'b0};
        end
        return nxt;
    endfunction

    // One restoring division iteration.
    function automatic div_st_t div_iter(input logic [31:0] rem, input logic [31:0] den,
                                         input logic nbit);
        div_st_t     nxt;
        logic [32:0] r;
        r = {rem, nbit};
        if (r >= {1'b0, den})
        begin
            nxt.rem  = 32'(r - {1'b0, den});
            nxt.qbit = 1'b1;
        end
        else
        begin
            nxt.rem  = r[31:0];
            nxt.qbit = 1'b0;
        end
        return nxt;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/rmsp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rmsp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/rmsp_msq.sv -----
// Mean-square store: read-modify-write of the running mean square, with bypass
// and the clearing sweep after reset. Uses rmsp_pkg and rmsp_ram.
`timescale 1ns / 1ps
`default_nettype none
module rmsp_msq #(
    parameter int ELEMENTS = rmsp_pkg::ELEMENTS_DEF,
    localparam int AW      = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  req_valid,
    input  wire logic [AW-1:0]         req_index,
    input  wire logic [63:0]           req_g2,
    input  wire rmsp_pkg::side_t       req_side,
    input  wire logic [15:0]           gamma,
    input  wire logic [31:0]           eps,
    output logic                       clearing,
    output logic                       v_valid,
    output logic [63:0]                v_data,
    output rmsp_pkg::side_t            v_side
);

    logic             clr_reg;
    logic [AW-1:0]    clr_cnt_reg;

    logic             s1_valid_reg;
    logic [AW-1:0]    s1_idx_reg;
    logic [63:0]      s1_g2_reg;
    rmsp_pkg::side_t  s1_side_reg;

    logic             fwd_hit_reg;
    logic [63:0]      fwd_data_reg;
    logic [63:0]      ram_q;

    logic             v_valid_reg;
    logic [63:0]      v_reg;
    rmsp_pkg::side_t  v_side_reg;

    logic [63:0]      s_old;
    logic [81:0]      mix;
    logic [63:0]      s_new;
    logic             s_sat;
    logic [64:0]      vsum;
    logic [63:0]      v_next;
    rmsp_pkg::side_t  side_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [63:0]      wr_data;

    rmsp_ram #(.WIDTH(64), .DEPTH(ELEMENTS)) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (en),
        .raddr (req_index),
        .rdata (ram_q)
    );

    always_comb
    begin
        s_old = fwd_hit_reg ? fwd_data_reg : ram_q;
        mix   = 82'(s_old) * 82'(gamma)
              + 82'(s1_g2_reg) * 82'(17'd65536 - {1'b0, gamma});
        s_sat = (mix[81:80] != 2'b00);
        s_new = s_sat ? {64{1'b1}} : mix[79:16];
        vsum  = {1'b0, s_new} + {33'd0, eps};
        v_next = vsum[64] ? {64{1'b1}} : vsum[63:0];
        side_next     = s1_side_reg;
        side_next.sat = s_sat | vsum[64];
    end

    always_comb
    begin
        wr_en   = clr_reg | (en & s1_valid_reg);
        wr_addr = clr_reg ? clr_cnt_reg : s1_idx_reg;
        wr_data = clr_reg ? 64'd0 : s_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            v_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(ELEMENTS - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (en)
            begin
                s1_valid_reg <= req_valid;
                // read issued now misses the write landing this same edge
                fwd_hit_reg  <= s1_valid_reg && (s1_idx_reg == req_index);
                v_valid_reg  <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg   <= req_index;
            s1_g2_reg    <= req_g2;
            s1_side_reg  <= req_side;
            fwd_data_reg <= s_new;
            v_reg        <= v_next;
            v_side_reg   <= side_next;
        end
    end

    assign clearing = clr_reg;
    assign v_valid  = v_valid_reg;
    assign v_data   = v_reg;
    assign v_side   = v_side_reg;

endmodule
`default_nettype wire

// ----- hdl/rmsp_sqrt.sv -----
// Pipelined floor square root, 64-bit radicand to 32-bit root, two bits per stage.
// Uses rmsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmsp_sqrt (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_vld,
    input  wire logic [63:0]      radicand,
    input  wire rmsp_pkg::side_t  in_side,
    output logic                  out_vld,
    output logic [31:0]           root,
    output rmsp_pkg::side_t       out_side
);

    localparam int NS = rmsp_pkg::SQRT_STG;

    logic                 vld_reg  [NS];
    rmsp_pkg::sqrt_st_t   st_reg   [NS];
    logic [63:0]          rad_reg  [NS];
    rmsp_pkg::side_t      side_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic                 vld_in;
        rmsp_pkg::sqrt_st_t   st_in;
        logic [63:0]          rad_in;
        rmsp_pkg::side_t      side_in;
        rmsp_pkg::sqrt_st_t   st_mid;
        rmsp_pkg::sqrt_st_t   st_next;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_vld;
            assign st_in   = '0;
            assign rad_in  = radicand;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign st_in   = st_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            st_mid  = rmsp_pkg::sqrt_iter(st_in, rad_in[63-4*k -: 2]);
            st_next = rmsp_pkg::sqrt_iter(st_mid, rad_in[61-4*k -: 2]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k]   <= st_next;
                rad_reg[k]  <= rad_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign root     = st_reg[NS-1].root;
    assign out_side = side_reg[NS-1];

endmodule
`default_nettype wire

// ----- hdl/rmsp_div.sv -----
// Pipelined restoring divider: 56-bit numerator from the side struct over a
// 32-bit divisor, two quotient bits per stage. Uses rmsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmsp_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_vld,
    input  wire logic [31:0]      divisor,
    input  wire rmsp_pkg::side_t  in_side,
    output logic                  out_vld,
    output logic [rmsp_pkg::NUM_W-1:0] quotient,
    output rmsp_pkg::side_t       out_side
);

    localparam int NS = rmsp_pkg::DIV_STG;
    localparam int NW = rmsp_pkg::NUM_W;

    logic                 vld_reg  [NS];
    logic [31:0]          rem_reg  [NS];
    logic [NW-1:0]        q_reg    [NS];
    logic [31:0]          den_reg  [NS];
    rmsp_pkg::side_t      side_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic               vld_in;
        logic [31:0]        rem_in;
        logic [NW-1:0]      q_in;
        logic [31:0]        den_in;
        rmsp_pkg::side_t    side_in;
        rmsp_pkg::div_st_t  d0;
        rmsp_pkg::div_st_t  d1;
        logic [NW-1:0]      q_next;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = '0;
            assign q_in    = '0;
            assign den_in  = divisor;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            d0 = rmsp_pkg::div_iter(rem_in, den_in, side_in.num[NW-1-2*k]);
            d1 = rmsp_pkg::div_iter(d0.rem, den_in, side_in.num[NW-2-2*k]);
            q_next = q_in;
            q_next[NW-1-2*k] = d0.qbit;
            q_next[NW-2-2*k] = d1.qbit;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= d1.rem;
                q_reg[k]    <= q_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign quotient = q_reg[NS-1];
    assign out_side = side_reg[NS-1];

endmodule
`default_nettype wire

// ----- hdl/rmsprop_update.sv -----
// RMSProp update engine. Takes one request per clock while in_stall is low
// (element index, parameter, gradient) and returns the updated parameter, one
// result per clock in steady state while no result is held. The mean-square entry
// is read and written back in a single stage of a one-read/one-write RAM, with a
// bypass for back-to-back requests to the same element; the root (16 stages) and
// the divide (28 stages) are fully pipelined. After reset the block clears every
// entry of the mean-square RAM and holds in_stall high meanwhile;
// configuration writes are taken at any time but act on requests in flight, so
// write them only while the block is idle. A held result stalls the whole pipeline.
// Depends on rmsp_pkg, rmsp_msq, rmsp_sqrt, rmsp_div and rmsp_ram.
`timescale 1ns / 1ps
`default_nettype none
module rmsprop_update #(
    parameter int ELEMENTS = rmsp_pkg::ELEMENTS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire rmsp_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output rmsp_pkg::out_item_t       out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int NW = rmsp_pkg::NUM_W;

    logic [15:0] decay_reg;
    logic [23:0] lr_reg;
    logic [31:0] eps_reg;

    logic        adv;
    logic        clearing;
    logic        accept;

    logic [31:0]     gmag;
    logic            gneg;
    logic [63:0]     g2;
    rmsp_pkg::side_t req_side;
    logic [26:0]     red;
    logic [AW-1:0]   idx;

    logic            v_valid;
    logic [63:0]     v_data;
    rmsp_pkg::side_t v_side;

    logic            r_valid;
    logic [31:0]     r_data;
    rmsp_pkg::side_t r_side;
    logic [31:0]     den;

    logic            q_valid;
    logic [NW-1:0]   q_data;
    rmsp_pkg::side_t q_side;

    logic [63:0]     np;
    logic            np_hi;
    logic            np_lo;

    logic                 out_valid_reg;
    rmsp_pkg::out_item_t  out_reg;
    rmsp_pkg::out_item_t  out_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= rmsp_pkg::DECAY_RST;
            lr_reg    <= rmsp_pkg::LR_RST;
            eps_reg   <= rmsp_pkg::EPS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rmsp_pkg::REG_DECAY: decay_reg <= cfg_data[15:0];
                rmsp_pkg::REG_LR:    lr_reg    <= cfg_data[23:0];
                rmsp_pkg::REG_EPS:   eps_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv || clearing;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        gneg = in_data.gradient[31];
        gmag = gneg ? 32'(~in_data.gradient + 32'sd1) : in_data.gradient;
        g2   = 64'(gmag) * 64'(gmag);
        req_side.param = in_data.param_value;
        req_side.gneg  = gneg;
        req_side.sat   = 1'b0;
        req_side.num   = NW'(NW'(lr_reg) * NW'(gmag));
        // index modulo ELEMENTS by shifted compare-subtract
        red = 27'(in_data.element_index);
        for (int j = 9; j >= 0; j--)
        begin
            if (red >= (27'(ELEMENTS) << j))
            begin
                red = red - (27'(ELEMENTS) << j);
            end
        end
        idx = red[AW-1:0];
    end

    rmsp_msq #(.ELEMENTS(ELEMENTS)) u_msq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .req_valid (accept),
        .req_index (idx),
        .req_g2    (g2),
        .req_side  (req_side),
        .gamma     (decay_reg),
        .eps       (eps_reg),
        .clearing  (clearing),
        .v_valid   (v_valid),
        .v_data    (v_data),
        .v_side    (v_side)
    );

    rmsp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (v_valid),
        .radicand (v_data),
        .in_side  (v_side),
        .out_vld  (r_valid),
        .root     (r_data),
        .out_side (r_side)
    );

    assign den = (r_data == 32'd0) ? 32'd1 : r_data;

    rmsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (r_valid),
        .divisor  (den),
        .in_side  (r_side),
        .out_vld  (q_valid),
        .quotient (q_data),
        .out_side (q_side)
    );

    always_comb
    begin
        if (q_side.gneg)
        begin
            np = {{32{q_side.param[31]}}, q_side.param} + 64'(q_data);
        end
        else
        begin
            np = {{32{q_side.param[31]}}, q_side.param} - 64'(q_data);
        end
        np_hi = !np[63] && (np[62:31] != 32'd0);
        np_lo = np[63] && (np[62:31] != {32{1'b1}});
        if (np_hi)
        begin
            out_next.new_param = 32'sh7FFF_FFFF;
        end
        else if (np_lo)
        begin
            out_next.new_param = 32'sh8000_0000;
        end
        else
        begin
            out_next.new_param = np[31:0];
        end
        out_next.saturated = q_side.sat | np_hi | np_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking rmsprop_update regression: directed table, config corners, random requests.
// Predicts each result from its own mean-square copy; depends on rmsp_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;

    localparam int NELEM     = 1024;
    localparam int MAX_CYCLES = 2000000;
    localparam int NDIR      = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    rmsp_pkg::in_item_t   in_data;
    logic                 out_valid;
    logic                 out_stall;
    rmsp_pkg::out_item_t  out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [31:0]          cfg_data;

    rmsprop_update i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [63:0] msq_model [NELEM];
    logic [15:0] gamma_q;
    logic [23:0] lr_q;
    logic [31:0] eps_q;

    rmsp_pkg::out_item_t pending_results[$];
    int          errors;
    int          cycle_cnt;
    int          send_idle_pct;
    int          recv_stall_pct;

    typedef struct {
        logic [9:0]  idx;
        logic [31:0] p;
        logic [31:0] g;
        logic        chk;
        logic [31:0] np;
        logic        sat;
    } stim_row_t;

    stim_row_t directed [NDIR];

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES)
        begin
            $display("rmsprop_update regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // computes the update and advances the mean-square copy
    function automatic rmsp_pkg::out_item_t rmsprop_predict(input rmsp_pkg::in_item_t req);
        rmsp_pkg::out_item_t o;
        logic        gneg;
        logic [31:0] gmag;
        logic [63:0] g2;
        logic [127:0] mix;
        logic [63:0] s;
        logic [64:0] v;
        logic [63:0] r;
        logic [63:0] stp;
        logic signed [63:0] np;
        logic        sat;
        int          k;
        k    = req.element_index % NELEM;
        sat  = 1'b0;
        gneg = req.gradient[31];
        gmag = gneg ? 32'(-req.gradient) : req.gradient;
        g2   = 64'(gmag) * 64'(gmag);
        mix  = 128'(msq_model[k]) * 128'(gamma_q)
             + 128'(g2) * 128'(17'd65536 - 17'(gamma_q));
        if (mix[127:80] != 0)
        begin
            s = '1;
            sat = 1'b1;
        end
        else
            s = mix[79:16];
        msq_model[k] = s;
        v = 65'(s) + 65'(eps_q);
        if (v[64])
        begin
            v = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
            sat = 1'b1;
        end
        r = root_floor(v[63:0]);
        if (r == 0)
            r = 1;
        stp = (64'(lr_q) * 64'(gmag)) / r;
        np = gneg ? 64'(signed'(req.param_value)) + signed'(stp)
                  : 64'(signed'(req.param_value)) - signed'(stp);
        if (np > 64'sd2147483647)
        begin
            np = 64'sd2147483647;
            sat = 1'b1;
        end
        else if (np < -64'sd2147483648)
        begin
            np = -64'sd2147483648;
            sat = 1'b1;
        end
        o.new_param = np[31:0];
        o.saturated = sat;
        return o;
    endfunction

    task automatic write_reg(input rmsp_pkg::cfg_reg_t which, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (which)
            rmsp_pkg::REG_DECAY: gamma_q = val[15:0];
            rmsp_pkg::REG_LR:    lr_q    = val[23:0];
            rmsp_pkg::REG_EPS:   eps_q   = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one request through the input handshake, with a random gap first;
    // valid stays up after the handshake so requests can follow back to back
    task automatic send_request(input rmsp_pkg::in_item_t req, input logic chk,
                                input rmsp_pkg::out_item_t want);
        rmsp_pkg::out_item_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = rmsprop_predict(req);
        if (chk && pred != want)
        begin
            $error("table row disagrees with predictor: %h vs %h", want, pred);
            errors++;
        end
        pending_results.insert(pending_results.size(), pred);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    // result checker; stall decided at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing expected");
                    errors++;
                end
                else
                begin
                    if (out_data.new_param !== pending_results[0].new_param)
                    begin
                        $error("new_param: expected %h actual %h",
                               pending_results[0].new_param, out_data.new_param);
                        errors++;
                    end
                    if (out_data.saturated !== pending_results[0].saturated)
                    begin
                        $error("saturated: expected %b actual %b",
                               pending_results[0].saturated, out_data.saturated);
                        errors++;
                    end
                    void'(pending_results.pop_front());
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic rmsp_pkg::in_item_t rand_request(input int mode);
        rmsp_pkg::in_item_t q;
        q.element_index = (mode == 0) ? 10'($urandom_range(7)) : 10'($urandom);
        q.param_value   = $urandom;
        case ($urandom_range(3))
            0: q.gradient = $urandom;
            1: q.gradient = 32'(signed'($urandom_range(131072)) - 65536);
            2: q.gradient = {{16{1'b0}}, 16'($urandom)};
            default: q.gradient = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
        return q;
    endfunction

    initial
    begin : stimulus
        rmsp_pkg::in_item_t  req;
        rmsp_pkg::out_item_t want;
        int        ph;
        int        n;
        errors = 0;
        cycle_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rmsp_pkg::REG_DECAY;
        cfg_data = '0;
        gamma_q = rmsp_pkg::DECAY_RST;
        lr_q = rmsp_pkg::LR_RST;
        eps_q = rmsp_pkg::EPS_RST;
        foreach (msq_model[k])
            msq_model[k] = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero gradient leaves param alone; extremes of param with big steps
        directed = '{
            '{10'd0, 32'h0001_0000, 32'h0, 1'b1, 32'h0001_0000, 1'b0},
            '{10'd1023, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0},
            '{10'd5, 32'h8000_0000, 32'h0, 1'b1, 32'h8000_0000, 1'b0},
            '{10'd2, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
            '{10'd3, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
            '{10'd3, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
            '{10'd4, 32'h0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
            '{10'd4, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
            '{10'd512, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
            '{10'd512, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0, 1'b0}
        };
        foreach (directed[i])
        begin
            req.element_index = directed[i].idx;
            req.param_value   = directed[i].p;
            req.gradient      = directed[i].g;
            want.new_param    = directed[i].np;
            want.saturated    = directed[i].sat;
            send_request(req, directed[i].chk, want);
        end
        drain_results();

        // eps zero gives the zero-root case; then largest eps and decay
        write_reg(rmsp_pkg::REG_EPS, 32'h0);
        write_reg(rmsp_pkg::REG_LR, 24'hFF_FFFF);
        req = '{10'd900, 32'h0, 32'h0};
        send_request(req, 1'b0, want);
        req = '{10'd901, 32'h1234_5678, 32'h0000_0001};
        send_request(req, 1'b0, want);
        drain_results();
        write_reg(rmsp_pkg::REG_EPS, 32'hFFFF_FFFF);
        write_reg(rmsp_pkg::REG_DECAY, 16'hFFFF);
        req = '{10'd2, 32'h0, 32'h8000_0000};
        send_request(req, 1'b0, want);
        drain_results();
        write_reg(rmsp_pkg::REG_DECAY, 16'h0);

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            case (ph)
                0: begin write_reg(rmsp_pkg::REG_DECAY, rmsp_pkg::DECAY_RST);
                         write_reg(rmsp_pkg::REG_LR, rmsp_pkg::LR_RST);
                         write_reg(rmsp_pkg::REG_EPS, rmsp_pkg::EPS_RST); end
                3: write_reg(rmsp_pkg::REG_DECAY, 16'h0);
                4: write_reg(rmsp_pkg::REG_DECAY, 16'hFFFF);
                5: write_reg(rmsp_pkg::REG_LR, 24'h0);
                6: begin write_reg(rmsp_pkg::REG_LR, 24'($urandom));
                         write_reg(rmsp_pkg::REG_EPS, $urandom);
                         write_reg(rmsp_pkg::REG_DECAY, 16'($urandom)); end
                default: write_reg(rmsp_pkg::REG_LR, 24'($urandom_range(65536)));
            endcase
            for (n = 0; n < 175; n++)
                send_request(rand_request(n % 3), 1'b0, want);
            drain_results();
        end

        if (errors == 0)
            $display("rmsprop_update regression: pass");
        else
            $display("rmsprop_update regression: fail");
        $finish;
    end
endmodule
